// ===== sv/spq_pkg.sv =====
// Shared types and constants for the sorted priority queue.
package spq_pkg;

  localparam int Depth    = 16;
  localparam int CountW   = $clog2(Depth + 1);
  localparam int CapW     = 5;
  localparam int CmpW     = (CountW > CapW) ? CountW : CapW;
  localparam logic [CapW-1:0] CapReset = CapW'(16);

  typedef enum logic {
    ACT_ENQ = 1'b0,
    ACT_DEQ = 1'b1
  } action_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    logic [7:0] prio;
    logic [7:0] chr;
  } entry_t;

  typedef struct packed {
    action_e    action;
    logic [7:0] entry_priority;
    logic [7:0] entry_char;
  } in_req_t;

  typedef struct packed {
    logic [7:0]        out_priority;
    logic [7:0]        out_char;
    status_e           status;
    logic [CountW-1:0] count;
  } out_rsp_t;

  // broadcast to every cell of the chain
  typedef struct packed {
    logic   ins;
    logic   del;
    entry_t new_entry;
  } cell_ctrl_t;

endpackage

// ===== sv/spq_cell.sv =====
// One slot of the sorted chain: holds an entry and shifts with its neighbours.
module spq_cell import spq_pkg::*; (
  input  logic       clk_i,
  input  cell_ctrl_t ctrl_i,
  input  logic       occ_i,
  input  logic       left_gt_i,
  input  entry_t     left_entry_i,
  input  entry_t     right_entry_i,
  output logic       gt_o,
  output entry_t     entry_o
);

  entry_t entry_q, entry_d;

  // strictly greater, so equal priorities keep arrival order
  assign gt_o    = occ_i && (entry_q.prio > ctrl_i.new_entry.prio);
  assign entry_o = entry_q;

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.ins) begin
      if (left_gt_i) begin
        entry_d = left_entry_i;
      end else if (gt_o || !occ_i) begin
        entry_d = ctrl_i.new_entry;
      end
    end else if (ctrl_i.del) begin
      entry_d = right_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

// ===== sv/sorted_priority_queue.sv =====
// Sorted priority queue: a chain of compare cells with a registered result.
//
// Requests arrive on in_valid_i/in_ready_o carrying an enqueue or a dequeue.
// Every request gives exactly one result on out_valid_o/out_ready_i: the
// dequeued entry (zero otherwise), a status and the entry count afterwards.
// Enqueue into a full queue or dequeue from an empty one is flagged and the
// queue is left as it was.
// The result is registered and valid the cycle after the request is accepted.
// Throughput: one request per cycle; each cell compares its priority with the
// new one, and all cells shift together when the request is accepted.
// If the receiver stalls, the one result register holds and in_ready_o drops
// until it is taken; a new request is accepted in the cycle it drains.
// cfg_we_i writes the capacity (values above the depth act as the depth).
// Reset empties the queue and sets capacity to 16; no clearing pass is needed
// as only slots below the count are ever read.
module sorted_priority_queue import spq_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  in_req_t         in_req_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output out_rsp_t        out_rsp_o,
  input  logic            cfg_we_i,
  input  logic [CapW-1:0] cfg_wdata_i
);

  logic [CapW-1:0]   cap_q;
  logic [CountW-1:0] count_q, count_d;
  logic              out_valid_q;
  out_rsp_t          rsp_q, rsp_d;
  logic              accept, full, empty;
  cell_ctrl_t        ctrl;
  logic   [Depth-1:0] occ, gt;
  entry_t [Depth-1:0] entries;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = !out_valid_q || out_ready_i;

  assign full  = (CmpW'(count_q) >= CmpW'(cap_q)) || (count_q == CountW'(Depth));
  assign empty = (count_q == '0);

  always_comb begin
    ctrl.ins       = accept && (in_req_i.action == ACT_ENQ) && !full;
    ctrl.del       = accept && (in_req_i.action == ACT_DEQ) && !empty;
    ctrl.new_entry = '{prio: in_req_i.entry_priority, chr: in_req_i.entry_char};
  end

  always_comb begin
    count_d = count_q;
    if (ctrl.ins) begin
      count_d = count_q + CountW'(1);
    end else if (ctrl.del) begin
      count_d = count_q - CountW'(1);
    end
    rsp_d              = rsp_q;
    rsp_d.out_priority = '0;
    rsp_d.out_char     = '0;
    rsp_d.status       = ST_OK;
    rsp_d.count        = count_d;
    if (in_req_i.action == ACT_ENQ) begin
      if (full) begin
        rsp_d.status = ST_FULL;
      end
    end else if (empty) begin
      rsp_d.status = ST_EMPTY;
    end else begin
      rsp_d.out_priority = entries[0].prio;
      rsp_d.out_char     = entries[0].chr;
    end
  end

  for (genvar i = 0; i < Depth; i++) begin : g_cell
    assign occ[i] = (CountW'(i) < count_q);
    spq_cell u_cell (
      .clk_i         (clk_i),
      .ctrl_i        (ctrl),
      .occ_i         (occ[i]),
      .left_gt_i     ((i == 0) ? 1'b0 : gt[(i == 0) ? 0 : i-1]),
      .left_entry_i  (entries[(i == 0) ? 0 : i-1]),
      .right_entry_i (entries[(i == Depth-1) ? i : i+1]),
      .gt_o          (gt[i]),
      .entry_o       (entries[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q       <= CapReset;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      count_q <= count_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rsp_q <= rsp_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = rsp_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CountW'(Depth))
    else $error("entry count beyond depth");

  a_deq_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_req_i.action == ACT_DEQ && empty) |=>
      (out_valid_q && rsp_q.status == ST_EMPTY && count_q == '0))
    else $error("dequeue from empty not flagged");

  a_enq_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_req_i.action == ACT_ENQ && !full) |=>
      (count_q == $past(count_q) + CountW'(1)))
    else $error("enqueue did not grow the queue");

  a_deq_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_req_i.action == ACT_DEQ && !empty) |=>
      (rsp_q.out_priority == $past(entries[0].prio) && rsp_q.count == count_q))
    else $error("dequeue result is not the head entry");

endmodule

// ===== bench/tb.sv =====
// Self-checking bench for the sorted priority queue: random requests, capacity changes, stalls.
module tb import spq_pkg::*; ();

  localparam int CycleLimit  = 500000;
  localparam int RandomItems = 1300;
  localparam int LongHold    = 300;

  // Tracks the queue contents and holds the results still owed by the block.
  class queue_tracker;
    entry_t      held[$];
    int unsigned cap_limit;
    out_rsp_t    expected_rsps[$];
    int          errors;

    function new();
      held.delete();
      expected_rsps.delete();
      cap_limit = Depth;
      errors    = 0;
    endfunction

    function void set_capacity(logic [CapW-1:0] value);
      cap_limit = (value > Depth) ? Depth : value;
    endfunction

    function void note_request(in_req_t req);
      out_rsp_t rsp;
      entry_t   e;
      int       pos;
      rsp = '0;
      rsp.status = ST_OK;
      if (req.action == ACT_ENQ) begin
        if (held.size() >= cap_limit) begin
          rsp.status = ST_FULL;
        end else begin
          // equal priorities go behind those already held
          pos = held.size();
          while (pos > 0 && held[pos-1].prio > req.entry_priority) pos--;
          e.prio = req.entry_priority;
          e.chr  = req.entry_char;
          held.insert(pos, e);
        end
      end else if (held.size() == 0) begin
        rsp.status = ST_EMPTY;
      end else begin
        e = held.pop_front();
        rsp.out_priority = e.prio;
        rsp.out_char     = e.chr;
      end
      rsp.count = CountW'(held.size());
      expected_rsps.push_back(rsp);
    endfunction

    function void report(string field, logic [7:0] exp_v, logic [7:0] got_v);
      $display("%0t: %s mismatch: expected %h, got %h", $time, field, exp_v, got_v);
      errors++;
    endfunction

    function void check_result(out_rsp_t got);
      out_rsp_t exp_rsp;
      if (expected_rsps.size() == 0) begin
        $display("%0t: unexpected result: expected none, got %h", $time, got);
        errors++;
      end else begin
        exp_rsp = expected_rsps.pop_front();
        if (got.out_priority !== exp_rsp.out_priority)
          report("out_priority", exp_rsp.out_priority, got.out_priority);
        if (got.out_char !== exp_rsp.out_char)
          report("out_char", exp_rsp.out_char, got.out_char);
        if (got.status !== exp_rsp.status)
          report("status", 8'(exp_rsp.status), 8'(got.status));
        if (got.count !== exp_rsp.count)
          report("count", 8'(exp_rsp.count), 8'(got.count));
      end
    endfunction
  endclass

  logic            clk_i       = 1'b0;
  logic            rst_ni      = 1'b0;
  logic            in_valid_i  = 1'b0;
  logic            in_ready_o;
  in_req_t         in_req_i    = '0;
  logic            out_valid_o;
  logic            out_ready_i = 1'b0;
  out_rsp_t        out_rsp_o;
  logic            cfg_we_i    = 1'b0;
  logic [CapW-1:0] cfg_wdata_i = '0;

  bit           hold_req = 1'b0;
  int           cycles   = 0;
  queue_tracker tracker  = new();

  sorted_priority_queue i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o === 1'b1) tracker.note_request(in_req_i);
      if (out_valid_o === 1'b1 && out_ready_i) tracker.check_result(out_rsp_o);
    end
  end

  initial begin
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("FAIL sorted_priority_queue");
    $finish;
  end

  // Result side: alternating runs of ready and stalls, plus one long hold-off on demand.
  initial begin : rsp_sink
    int stretch;
    int hold_left;
    bit stalling;
    stretch   = 0;
    hold_left = 0;
    stalling  = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = LongHold;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        if (stretch == 0) begin
          stalling = !stalling;
          if (stalling)
            stretch = ($urandom_range(9) == 0) ? $urandom_range(40, 10) : $urandom_range(3, 1);
          else
            stretch = ($urandom_range(9) == 0) ? $urandom_range(200, 50) : $urandom_range(12, 1);
        end
        stretch--;
        out_ready_i <= !stalling;
      end
    end
  end

  function automatic in_req_t make_req(action_e act, logic [7:0] prio, logic [7:0] chr);
    in_req_t req;
    req.action         = act;
    req.entry_priority = prio;
    req.entry_char     = chr;
    return req;
  endfunction

  function automatic int pick_gap(bit no_idle);
    int roll;
    roll = $urandom_range(99);
    if (no_idle || roll < 60) return 0;
    if (roll < 92) return $urandom_range(3, 1);
    return $urandom_range(30, 5);
  endfunction

  task automatic send_request(in_req_t req, int gap);
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_req_i   <= req;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (tracker.expected_rsps.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_capacity(int unsigned value);
    drain_results();
    repeat (2) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= CapW'(value);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    tracker.set_capacity(CapW'(value));
  endtask

  task automatic enq(logic [7:0] prio, logic [7:0] chr);
    send_request(make_req(ACT_ENQ, prio, chr), pick_gap(1'b0));
  endtask

  task automatic deq();
    send_request(make_req(ACT_DEQ, 8'($urandom_range(255)), 8'($urandom_range(255))),
                 pick_gap(1'b0));
  endtask

  initial begin : stimulus
    int          sent;
    int          phase;
    int          len;
    int          enq_pct;
    int          prio_max;
    int          roll;
    int unsigned cap;
    bit          no_idle;
    logic [7:0]  prio;
    in_req_t     req;
    sent  = 0;
    phase = 0;

    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    // zero capacity refuses every enqueue
    write_capacity(0);
    enq(8'h12, 8'h34);
    write_capacity(1);
    enq(8'h40, 8'h41);
    enq(8'h01, 8'h02);
    deq();
    // above the depth acts as the depth
    write_capacity(31);
    deq();
    enq(8'hFF, 8'h00);
    enq(8'h00, 8'hFF);
    enq(8'h80, 8'h55);
    enq(8'h80, 8'hAA);
    repeat (12) enq(8'($urandom_range(255)), 8'($urandom_range(255)));
    enq(8'h7F, 8'h7F);
    // lowered below the count: held entries stay, enqueues refused
    write_capacity(2);
    enq(8'h00, 8'h00);
    deq();
    deq();

    while (sent < RandomItems) begin
      roll = $urandom_range(9);
      case (roll)
        0:       cap = 0;
        1:       cap = $urandom_range(31, 17);
        2:       cap = 16;
        3:       cap = 1;
        default: cap = $urandom_range(16, 1);
      endcase
      write_capacity(cap);
      case ($urandom_range(3))
        0:       enq_pct = 25;
        1:       enq_pct = 50;
        2:       enq_pct = 75;
        default: enq_pct = 90;
      endcase
      prio_max = $urandom_range(1) ? 255 : 3;
      len      = $urandom_range(120, 20);
      no_idle  = ($urandom_range(4) == 0);
      if (phase == 2) begin
        // result side blocks for a long stretch while requests keep coming
        hold_req = 1'b1;
        no_idle  = 1'b1;
        enq_pct  = 50;
      end
      repeat (len) begin
        roll = $urandom_range(99);
        if (roll < 3)
          prio = 8'h00;
        else if (roll < 6)
          prio = 8'hFF;
        else
          prio = 8'($urandom_range(prio_max));
        req = make_req(($urandom_range(99) < enq_pct) ? ACT_ENQ : ACT_DEQ, prio,
                       8'($urandom_range(255)));
        send_request(req, pick_gap(no_idle));
        sent++;
        if ($urandom_range(49) == 0) drain_results();
      end
      phase++;
    end

    write_capacity(16);
    drain_results();
    repeat (5) @(negedge clk_i);
    if (tracker.errors == 0)
      $display("PASS sorted_priority_queue");
    else
      $display("FAIL sorted_priority_queue");
    $finish;
  end

endmodule
